FILE: hdl/llf_pkg.sv
// llf_pkg: shared types, widths and codes for the least-loaded fill unit
// no dependencies; imported by every module under hdl
package llf_pkg;

  localparam int MAX_SIDE_DEF = 8;
  localparam int HEIGHT_W     = 16;
  localparam int SIDE_W       = 4;
  localparam int UNITS_W      = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int POS_W        = 3;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS     = 1'b1;

  localparam logic [SIDE_W-1:0]  GRID_SIDE_RST = 4'd8;
  localparam logic [UNITS_W-1:0] UNITS_RST     = '0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_UPDATE,
    ST_DUMP_RD,
    ST_DUMP_WR
  } llf_state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic vld;
    logic first;
  } cmp_ctl_t;

  typedef struct packed {
    logic                vld;
    logic [HEIGHT_W-1:0] height;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                last;
  } dump_t;

endpackage

FILE: hdl/llf_store.sv
// llf_store: height memory, one write port and one registered read port
// depends on llf_pkg
module llf_store import llf_pkg::*; #(
  parameter int DEPTH  = MAX_SIDE_DEF * MAX_SIDE_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  mem_ctl_t            mem_ctl,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [HEIGHT_W-1:0] wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [HEIGHT_W-1:0] rd_data
);

  logic [HEIGHT_W-1:0] mem [DEPTH];
  logic [HEIGHT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (mem_ctl.re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/llf_argmin.sv
// llf_argmin: shared compare unit that tracks the lowest cell of a scan
// and offers its incremented height; depends on llf_pkg
module llf_argmin import llf_pkg::*; #(
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  cmp_ctl_t            cmp_ctl,
  input  logic [ADDR_W-1:0]   cmp_idx,
  input  logic [HEIGHT_W-1:0] rd_data,
  output logic [ADDR_W-1:0]   best_idx,
  output logic [HEIGHT_W-1:0] best_inc,
  output logic                best_sat
);

  logic [HEIGHT_W-1:0] best_val_r;
  logic [ADDR_W-1:0]   best_idx_r;

  // strict less-than keeps the first cell on ties
  always_ff @(posedge clk) begin
    if (cmp_ctl.vld && (cmp_ctl.first || (rd_data < best_val_r))) begin
      best_val_r <= rd_data;
      best_idx_r <= cmp_idx;
    end
  end

  assign best_idx = best_idx_r;
  assign best_inc = HEIGHT_W'(best_val_r + 1'b1);
  assign best_sat = (best_val_r == HEIGHT_MAX);

endmodule

FILE: hdl/llf_seq.sv
// llf_seq: sequencer for load, placement scans and grid dump
// depends on llf_pkg; drives llf_store and llf_argmin
module llf_seq import llf_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int ADDR_W   = 6,
  parameter int CNT_W    = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SIDE_W-1:0]   grid_side,
  input  logic [UNITS_W-1:0]  units_to_place,
  input  logic                in_valid,
  input  logic [HEIGHT_W-1:0] in_cell_height,
  output logic                load_rdy,
  output mem_ctl_t            mem_ctl,
  output logic [ADDR_W-1:0]   mem_waddr,
  output logic [HEIGHT_W-1:0] mem_wdata,
  output logic [ADDR_W-1:0]   mem_raddr,
  input  logic [HEIGHT_W-1:0] rd_data,
  output cmp_ctl_t            cmp_ctl,
  output logic [ADDR_W-1:0]   cmp_idx,
  input  logic [ADDR_W-1:0]   best_idx,
  input  logic [HEIGHT_W-1:0] best_inc,
  input  logic                best_sat,
  output dump_t               dump,
  input  logic                out_free
);

  localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

  llf_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0]   cells_r, cells_nxt;
  logic [SIDE_W-1:0]  side_r, side_nxt;
  logic [UNITS_W-1:0] units_r, units_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               rd_first_r, rd_first_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;

  logic [SIDE_W-1:0]   side;
  logic [2*SIDE_W-1:0] cells_full;
  logic [CNT_W-1:0]    cells;
  logic                accept;
  logic                load_done;
  logic                scan_issue;
  logic                dump_last;
  logic                col_wrap;

  // side clamped into 1..MAX_SIDE
  always_comb begin
    if (grid_side == '0) begin
      side = SIDE_W'(1);
    end else if (grid_side > MAX_SIDE_V) begin
      side = MAX_SIDE_V;
    end else begin
      side = grid_side;
    end
    cells_full = side * side;
    cells      = cells_full[CNT_W-1:0];
  end

  assign accept     = in_valid && (state_r == ST_LOAD);
  assign load_done  = (CNT_W'(load_cnt_r + 1'b1) >= cells);
  assign scan_issue = (addr_r < cells_r);
  assign dump_last  = (addr_r == CNT_W'(cells_r - 1'b1));
  assign col_wrap   = (SIDE_W'(col_r) == SIDE_W'(side_r - 1'b1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && load_done) begin
          state_nxt = (units_to_place == '0) ? ST_DUMP_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && rd_last_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (best_sat || (units_r == UNITS_W'(1))) begin
          state_nxt = ST_DUMP_RD;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_DUMP_RD: begin
        state_nxt = ST_DUMP_WR;
      end
      ST_DUMP_WR: begin
        if (out_free) begin
          state_nxt = dump_last ? ST_LOAD : ST_DUMP_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    load_rdy     = (state_r == ST_LOAD);
    mem_ctl      = '0;
    mem_waddr    = load_cnt_r[ADDR_W-1:0];
    mem_wdata    = in_cell_height;
    mem_raddr    = addr_r[ADDR_W-1:0];
    load_cnt_nxt = load_cnt_r;
    cells_nxt    = cells_r;
    side_nxt     = side_r;
    units_nxt    = units_r;
    addr_nxt     = addr_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    rd_vld_nxt   = 1'b0;
    rd_first_nxt = (addr_r == '0);
    rd_last_nxt  = dump_last;
    rd_idx_nxt   = addr_r[ADDR_W-1:0];
    dump.vld     = 1'b0;
    dump.height  = rd_data;
    dump.row     = row_r;
    dump.col     = col_r;
    dump.last    = dump_last;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          mem_ctl.we = 1'b1;
          if (load_done) begin
            load_cnt_nxt = '0;
            cells_nxt    = cells;
            side_nxt     = side;
            units_nxt    = units_to_place;
            addr_nxt     = '0;
            row_nxt      = '0;
            col_nxt      = '0;
          end else begin
            load_cnt_nxt = CNT_W'(load_cnt_r + 1'b1);
          end
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          mem_ctl.re = 1'b1;
          rd_vld_nxt = 1'b1;
          addr_nxt   = CNT_W'(addr_r + 1'b1);
        end
      end
      ST_UPDATE: begin
        addr_nxt  = '0;
        mem_waddr = best_idx;
        mem_wdata = best_inc;
        if (!best_sat) begin
          mem_ctl.we = 1'b1;
          units_nxt  = UNITS_W'(units_r - 1'b1);
        end
      end
      ST_DUMP_RD: begin
        mem_ctl.re = 1'b1;
      end
      ST_DUMP_WR: begin
        dump.vld = 1'b1;
        if (out_free) begin
          addr_nxt = CNT_W'(addr_r + 1'b1);
          if (col_wrap) begin
            col_nxt = '0;
            row_nxt = POS_W'(row_r + 1'b1);
          end else begin
            col_nxt = POS_W'(col_r + 1'b1);
          end
        end
      end
      default: begin
        load_rdy = 1'b0;
      end
    endcase
  end

  assign cmp_ctl.vld   = rd_vld_r;
  assign cmp_ctl.first = rd_first_r;
  assign cmp_idx       = rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r    <= cells_nxt;
    side_r     <= side_nxt;
    units_r    <= units_nxt;
    addr_r     <= addr_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    rd_first_r <= rd_first_nxt;
    rd_last_r  <= rd_last_nxt;
    rd_idx_r   <= rd_idx_nxt;
  end

endmodule

FILE: hdl/least_loaded_fill_unit.sv
// least_loaded_fill_unit: loads a square grid of heights, places units on the
// lowest cell one at a time, then reports every cell in row-major order
// loading writes each accepted height to the memory; each placed unit takes a scan
// (one memory read per cell through the shared compare unit), then one update
// the dump reads each cell and then waits for the output register; no other request
// is taken from the last cell until the final result is registered
// synchronous active-low reset: empty load, grid_side 8, units_to_place 0
module least_loaded_fill_unit import llf_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [HEIGHT_W-1:0]  in_cell_height,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [HEIGHT_W-1:0]  out_final_height,
  output logic [POS_W-1:0]     out_row_index,
  output logic [POS_W-1:0]     out_col_index,
  output logic                 out_last_cell
);

  localparam int MAX_CELLS = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);

  logic [SIDE_W-1:0]  grid_side_r;
  logic [UNITS_W-1:0] units_r;

  logic                out_valid_r;
  logic [HEIGHT_W-1:0] out_height_r;
  logic [POS_W-1:0]    out_row_r;
  logic [POS_W-1:0]    out_col_r;
  logic                out_last_r;

  logic                load_rdy;
  logic                out_free;
  mem_ctl_t            mem_ctl;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [HEIGHT_W-1:0] mem_wdata;
  logic [HEIGHT_W-1:0] rd_data;
  cmp_ctl_t            cmp_ctl;
  logic [ADDR_W-1:0]   cmp_idx;
  logic [ADDR_W-1:0]   best_idx;
  logic [HEIGHT_W-1:0] best_inc;
  logic                best_sat;
  dump_t               dump;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RST;
      units_r     <= UNITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIDE: grid_side_r <= cfg_wdata[SIDE_W-1:0];
        CFG_UNITS:     units_r     <= cfg_wdata[UNITS_W-1:0];
        default:       units_r     <= units_r;
      endcase
    end
  end

  llf_seq #(
    .MAX_SIDE (MAX_SIDE),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .grid_side      (grid_side_r),
    .units_to_place (units_r),
    .in_valid       (in_valid),
    .in_cell_height (in_cell_height),
    .load_rdy       (load_rdy),
    .mem_ctl        (mem_ctl),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .rd_data        (rd_data),
    .cmp_ctl        (cmp_ctl),
    .cmp_idx        (cmp_idx),
    .best_idx       (best_idx),
    .best_inc       (best_inc),
    .best_sat       (best_sat),
    .dump           (dump),
    .out_free       (out_free)
  );

  llf_store #(
    .DEPTH  (MAX_CELLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rd_data (rd_data)
  );

  llf_argmin #(
    .ADDR_W (ADDR_W)
  ) u_argmin (
    .clk      (clk),
    .cmp_ctl  (cmp_ctl),
    .cmp_idx  (cmp_idx),
    .rd_data  (rd_data),
    .best_idx (best_idx),
    .best_inc (best_inc),
    .best_sat (best_sat)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dump.vld && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dump.vld && out_free) begin
      out_height_r <= dump.height;
      out_row_r    <= dump.row;
      out_col_r    <= dump.col;
      out_last_r   <= dump.last;
    end
  end

  assign in_stall         = !load_rdy;
  assign out_valid        = out_valid_r;
  assign out_final_height = out_height_r;
  assign out_row_index    = out_row_r;
  assign out_col_index    = out_col_r;
  assign out_last_cell    = out_last_r;

  // leaving the load phase always follows an accepted request
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("load phase left without a request");

  // the last cell of a square grid sits on the diagonal
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_cell) |-> (out_row_index == out_col_index))
    else $error("last cell off the diagonal");

  // no new request while a dump is still in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && !out_last_cell))
    else $error("request taken during dump");

endmodule

FILE: verif/testbench.sv
// testbench for least_loaded_fill_unit: loads grids, places units on the lowest cell
// and checks every reported cell against a predictor kept in step with each request
// depends on hdl/llf_pkg.sv and hdl/least_loaded_fill_unit.sv
module testbench;
  import llf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES    = 20;
  localparam int unsigned RANDOM_ITEMS  = 110;
  localparam int unsigned MAX_CELLS     = MAX_SIDE_DEF * MAX_SIDE_DEF;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                last;
  } cell_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [HEIGHT_W-1:0]  in_cell_height;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [HEIGHT_W-1:0]  out_final_height;
  logic [POS_W-1:0]     out_row_index;
  logic [POS_W-1:0]     out_col_index;
  logic                 out_last_cell;

  logic [SIDE_W-1:0]   side_reg;
  logic [UNITS_W-1:0]  units_reg;
  logic [HEIGHT_W-1:0] height_store [MAX_CELLS];
  int unsigned         cells_loaded;
  cell_report_t        expected_cells [$];

  bit          no_gaps;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stall_left;

  least_loaded_fill_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cell_height   (in_cell_height),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_final_height (out_final_height),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_last_cell    (out_last_cell)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned side_in_effect(input logic [SIDE_W-1:0] side);
    if (side == '0) return 1;
    if (side > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return side;
  endfunction

  function automatic void place_on_lowest(input int unsigned cells);
    int unsigned lowest;
    int unsigned placed;
    int unsigned k;
    for (placed = 0; placed < units_reg; placed++) begin
      lowest = 0;
      for (k = 1; k < cells; k++) begin
        if (height_store[k] < height_store[lowest]) lowest = k;
      end
      if (height_store[lowest] == HEIGHT_MAX) break;
      height_store[lowest] = height_store[lowest] + 1'b1;
    end
  endfunction

  // returns 1 when this request completes the grid
  function automatic bit accept_height(input logic [HEIGHT_W-1:0] height);
    int unsigned side;
    int unsigned cells;
    int unsigned k;
    cell_report_t rep;
    side  = side_in_effect(side_reg);
    cells = side * side;
    if (cells_loaded < MAX_CELLS) height_store[cells_loaded] = height;
    cells_loaded++;
    if (cells_loaded < cells) return 1'b0;
    cells_loaded = 0;
    place_on_lowest(cells);
    for (k = 0; k < cells; k++) begin
      rep.height = height_store[k];
      rep.row    = POS_W'(k / side);
      rep.col    = POS_W'(k % side);
      rep.last   = (k + 1 == cells);
      expected_cells.push_back(rep);
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : check_results
    cell_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $error("result with no request pending: row %0d col %0d height %0d",
               out_row_index, out_col_index, out_final_height);
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        if (out_final_height !== want.height) begin
          $error("final_height: expected %0d, actual %0d", want.height, out_final_height);
          mismatches++;
        end
        if (out_row_index !== want.row) begin
          $error("row_index: expected %0d, actual %0d", want.row, out_row_index);
          mismatches++;
        end
        if (out_col_index !== want.col) begin
          $error("col_index: expected %0d, actual %0d", want.col, out_col_index);
          mismatches++;
        end
        if (out_last_cell !== want.last) begin
          $error("last_cell: expected %0d, actual %0d", want.last, out_last_cell);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) stall_left = no_gaps ? 0 : $urandom_range(0, 16);
      else if (!out_valid && stall_left == 0 && !no_gaps && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 16);
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_cell(input logic [HEIGHT_W-1:0] height, output bit grid_done);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cell_height <= height;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    grid_done = accept_height(height);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_GRID_SIDE: side_reg = data[SIDE_W-1:0];
      CFG_UNITS:     units_reg = data[UNITS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [HEIGHT_W-1:0] pick_height(input int unsigned mode);
    case (mode)
      0:       return HEIGHT_W'($urandom_range(0, 15));
      1:       return HEIGHT_W'($urandom_range(0, 65535));
      default: return HEIGHT_W'($urandom_range(65528, 65535));
    endcase
  endfunction

  function automatic logic [SIDE_W-1:0] pick_side(input bit oversize);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (oversize || r == 1) return SIDE_W'($urandom_range(MAX_SIDE_DEF + 1, 15));
    if (r == 0) return '0;
    if (r < 16) return SIDE_W'($urandom_range(1, 3));
    return SIDE_W'($urandom_range(4, MAX_SIDE_DEF - 1));
  endfunction

  // picks no units one time in five, else fewer units for larger grids
  function automatic logic [CFG_W-1:0] pick_units();
    int unsigned cells;
    cells = side_in_effect(side_reg) * side_in_effect(side_reg);
    if ($urandom_range(0, 4) == 0) return '0;
    return CFG_W'($urandom_range(1, 1200 / (cells + 2)));
  endfunction

  function automatic logic [CFG_W-1:0] side_word(input logic [SIDE_W-1:0] side);
    logic [CFG_W-1:0] word;
    word = CFG_W'($urandom_range(0, 65535));
    word[SIDE_W-1:0] = side;
    return word;
  endfunction

  // reset values: 8 x 8 grid, nothing placed, heights come back unchanged
  task automatic test_reset_defaults();
    bit done;
    no_gaps = 1'b0;
    do send_cell(pick_height(1), done); while (!done);
    wait_idle();
  endtask

  task automatic test_single_cell_extremes();
    bit done;
    write_reg(CFG_GRID_SIDE, 16'h0001);
    write_reg(CFG_UNITS, 16'h0000);
    send_cell(HEIGHT_MAX, done);
    send_cell('0, done);
    wait_idle();
    write_reg(CFG_UNITS, 16'hFFFF);
    send_cell('0, done);
    wait_idle();
    send_cell(HEIGHT_MAX, done);
    wait_idle();
  endtask

  // side of zero behaves as one, upper data bits are ignored
  task automatic test_side_encoding();
    bit done;
    write_reg(CFG_GRID_SIDE, 16'hFFF0);
    write_reg(CFG_UNITS, 16'h0003);
    send_cell(16'd7, done);
    wait_idle();
  endtask

  task automatic test_tie_break();
    logic [HEIGHT_W-1:0] heights [4] = '{16'd5, 16'd3, 16'd3, 16'd7};
    bit done;
    write_reg(CFG_GRID_SIDE, 16'h0002);
    write_reg(CFG_UNITS, 16'h0003);
    foreach (heights[i]) send_cell(heights[i], done);
    wait_idle();
  endtask

  task automatic test_saturation();
    logic [HEIGHT_W-1:0] heights [4] = '{HEIGHT_MAX, HEIGHT_MAX - 1'b1, HEIGHT_MAX, HEIGHT_MAX};
    bit done;
    write_reg(CFG_GRID_SIDE, 16'h0002);
    write_reg(CFG_UNITS, 16'h0005);
    foreach (heights[i]) send_cell(heights[i], done);
    wait_idle();
  endtask

  task automatic test_side_change_mid_load();
    bit done;
    write_reg(CFG_GRID_SIDE, 16'h0003);
    write_reg(CFG_UNITS, 16'h0002);
    repeat (5) send_cell(pick_height(0), done);
    wait_idle();
    write_reg(CFG_GRID_SIDE, 16'hA002);
    send_cell(pick_height(0), done);
    wait_idle();
    repeat (2) send_cell(pick_height(0), done);
    wait_idle();
    write_reg(CFG_GRID_SIDE, 16'h0003);
    do send_cell(pick_height(0), done); while (!done);
    wait_idle();
  endtask

  task automatic test_random_grids();
    int unsigned sent;
    int unsigned cells;
    int unsigned mode;
    bit          first;
    bit          done;
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      no_gaps = ($urandom_range(0, 3) == 0);
      write_reg(CFG_GRID_SIDE, side_word(pick_side(first)));
      write_reg(CFG_UNITS, pick_units());
      first = 1'b0;
      mode  = $urandom_range(0, 2);
      cells = side_in_effect(side_reg) * side_in_effect(side_reg);
      if (cells > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, cells - 1)) begin
          send_cell(pick_height(mode), done);
          sent++;
        end
        wait_idle();
        write_reg(CFG_GRID_SIDE, side_word(pick_side(1'b0)));
        write_reg(CFG_UNITS, pick_units());
      end
      do begin
        send_cell(pick_height(mode), done);
        sent++;
      end while (!done);
    end
    wait_idle();
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_GRID_SIDE;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_cell_height <= '0;
    side_reg       = GRID_SIDE_RST;
    units_reg      = UNITS_RST;
    cells_loaded   = 0;
    no_gaps        = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_single_cell_extremes();
    test_side_encoding();
    test_tie_break();
    test_saturation();
    test_side_change_mid_load();
    test_random_grids();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/llf_pkg.sv
hdl/llf_store.sv
hdl/llf_argmin.sv
hdl/llf_seq.sv
hdl/least_loaded_fill_unit.sv
verif/testbench.sv
